FILE: sv/slc_pkg.sv
package slc_pkg;

  // Input modes
  localparam logic [1:0] MODE_RX      = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  // Line events
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_LINK_UP   = 3'd1;
  localparam logic [2:0] EV_FAIL      = 3'd2;
  localparam logic [2:0] EV_PROGRESS  = 3'd3;
  localparam logic [2:0] EV_IP        = 3'd4;
  localparam logic [2:0] EV_STORED    = 3'd5;
  localparam logic [2:0] EV_DROPPED   = 3'd6;
  localparam logic [2:0] EV_EMPTY     = 3'd7;

  // Framing characters
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Status patterns: whole-line matches plus the "@IP" prefix
  localparam int PAT_COUNT   = 6;
  localparam int PAT_MAX_LEN = 18;
  localparam int PAT_W       = 8 * PAT_MAX_LEN;
  localparam int IP_BIT      = 6;
  localparam int LIVE_W      = 7;
  localparam logic [LIVE_W-1:0] LIVE_ALL = '1;

  localparam logic [PAT_W-1:0] PAT_TEXT [PAT_COUNT] = '{
    PAT_W'({"@SERVER", "_OK"}),
    PAT_W'({"@SERVER", "_FAIL"}),
    PAT_W'({"@WIFI", "_FAIL"}),
    PAT_W'("@WIFI_OK"),
    PAT_W'({"@WIFI", "_CONNECTING"}),
    PAT_W'({"@SERVER", "_CONNECTING"})
  };
  localparam logic [4:0] PAT_LEN [PAT_COUNT] = '{
    5'd10, 5'd12, 5'd10, 5'd8, 5'd16, 5'd18
  };
  localparam logic [2:0] PAT_EVENT [PAT_COUNT] = '{
    EV_LINK_UP, EV_FAIL, EV_FAIL, EV_PROGRESS, EV_PROGRESS, EV_PROGRESS
  };
  localparam logic [7:0] IP_TEXT [3] = '{8'h40, 8'h49, 8'h50};

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
    logic [6:0] read_index;
  } slc_in_t;

  typedef struct packed {
    logic       connected;
    logic       packet_ready;
    logic [7:0] read_char;
    logic [2:0] line_event;
  } slc_out_t;

  // Per-item status handed from the parser core to the output pipeline
  typedef struct packed {
    logic       connected;
    logic       packet_ready;
    logic [2:0] line_event;
    logic       rd_hit;
  } slc_step_t;

  // Character p of pattern k; caller guarantees p is below the pattern length
  function automatic logic [7:0] pat_byte(input int k, input logic [4:0] p);
    int         base;
    logic [7:0] ch;
    base = 8 * (int'(PAT_LEN[k]) - 1 - int'(p));
    ch   = PAT_TEXT[k][base +: 8];
    return ch;
  endfunction

endpackage

FILE: sv/status_line_classifier_unit.sv
// Status line classifier.
// Input channel in_valid/in_ready/in_item carries one item per handshake:
// mode 0 feeds one received byte, mode 1 releases the packet slot, mode 2
// reads one character of the stored packet at read_index.
// Output channel out_valid/out_ready/out_item returns exactly one result
// per input item, in order: connection flag, packet-ready flag, the read
// character (0 outside mode 2 or at/past the packet length) and the line
// event code, which is nonzero only on a line feed.
// The parser state, stage 1 and the packet buffer read load at the input
// accept; the output register loads from stage 1 when it is free or
// drains, and out_valid rises with it. Throughput is one item per cycle
// while out_ready stays high.
// The line and packet live in two buffers of LINE_MAX bytes that swap roles
// when a command line is stored, so storing needs no copy.
// Reset clears the line, packet length, flags and both pipeline stages;
// buffer contents are not cleared and need no clearing pass.
// When the receiver stalls, one more item is accepted into the pipeline
// register; after that in_ready drops until out_ready returns.
module status_line_classifier_unit
  import slc_pkg::*;
#(
  parameter int LINE_MAX = 127
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  slc_in_t  in_item,
  output logic     out_valid,
  input  logic     out_ready,
  output slc_out_t out_item
);

  slc_step_t  step;
  logic [7:0] rd_data;
  logic       in_fire;
  logic       s1_move;

  logic       s1_valid_r, s1_valid_nxt;
  slc_step_t  s1_step_r;
  logic       out_valid_r, out_valid_nxt;
  slc_out_t   out_item_r, out_item_nxt;

  slc_core #(
    .LINE_MAX(LINE_MAX)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_fire),
    .item   (in_item),
    .step   (step),
    .rd_data(rd_data)
  );

  // Handshake: stage 1 moves when the output register is free or drains
  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;
  assign in_fire  = in_valid && in_ready;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_move);
  assign out_valid_nxt = s1_move || (out_valid_r && !out_ready);

  // Build the result item from stage 1 and the buffer read data
  always_comb begin
    out_item_nxt.connected    = s1_step_r.connected;
    out_item_nxt.packet_ready = s1_step_r.packet_ready;
    out_item_nxt.read_char    = s1_step_r.rd_hit ? rd_data : 8'd0;
    out_item_nxt.line_event   = s1_step_r.line_event;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload unless the stage advances
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_step_r <= step;
    end
    if (s1_move) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_move |=> s1_valid_r && $stable(s1_step_r))
    else $error("stage 1 item lost while stalled");

  a_fire_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted item missing from stage 1");

  a_char_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.read_char != 8'd0) |-> (out_item_r.line_event == EV_NONE))
    else $error("read character reported with a line event");

endmodule

FILE: sv/slc_core.sv
module slc_core
  import slc_pkg::*;
#(
  parameter int LINE_MAX = 127
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  slc_in_t   item,
  output slc_step_t step,
  output logic [7:0] rd_data
);

  localparam int LEN_W  = $clog2(LINE_MAX + 1);
  localparam int ADDR_W = $clog2(LINE_MAX);
  localparam int CMP_W  = (LEN_W > 7) ? LEN_W : 7;

  // Parser state
  logic [LEN_W-1:0]  line_len_r, line_len_nxt;
  logic [LIVE_W-1:0] live_r, live_nxt;
  logic [LEN_W-1:0]  pkt_len_r, pkt_len_nxt;
  logic              conn_r, conn_nxt;
  logic              full_r, full_nxt;
  logic              line_bank_r, line_bank_nxt;

  // Two line buffers: one collects the line, the other holds the packet
  logic [7:0]        buf_mem [2][LINE_MAX];
  logic [7:0]        rd_data_r;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CMP_W-1:0]  idx_ext;
  logic [2:0]        match_ev;
  logic [2:0]        ev;

  assign idx_ext = CMP_W'(item.read_index);
  assign rd_addr = idx_ext[ADDR_W-1:0];
  assign wr_addr = line_len_r[ADDR_W-1:0];

  // Classify the line collected so far against the whole-line patterns, then the "@IP" prefix
  always_comb begin
    match_ev = EV_NONE;
    for (int k = PAT_COUNT - 1; k >= 0; k--) begin
      if (live_r[k] && (line_len_r == LEN_W'(PAT_LEN[k]))) begin
        match_ev = PAT_EVENT[k];
      end
    end
    if ((match_ev == EV_NONE) && live_r[IP_BIT] && (line_len_r >= LEN_W'(3))) begin
      match_ev = EV_IP;
    end
  end

  // Next state for one accepted item
  always_comb begin
    line_len_nxt  = line_len_r;
    live_nxt      = live_r;
    pkt_len_nxt   = pkt_len_r;
    conn_nxt      = conn_r;
    full_nxt      = full_r;
    line_bank_nxt = line_bank_r;
    ev            = EV_NONE;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    case (item.mode)
      MODE_RX: begin
        if (item.rx_byte == CHAR_LF) begin
          if (line_len_r == '0) begin
            ev = EV_EMPTY;
          end else begin
            ev = match_ev;
            if (match_ev == EV_LINK_UP) begin
              conn_nxt = 1'b1;
            end else if (match_ev == EV_FAIL) begin
              conn_nxt = 1'b0;
            end else if (match_ev == EV_NONE) begin
              if (full_r) begin
                ev = EV_DROPPED;
              end else begin
                // Swap buffers: the finished line becomes the packet
                ev            = EV_STORED;
                full_nxt      = 1'b1;
                pkt_len_nxt   = line_len_r;
                line_bank_nxt = ~line_bank_r;
              end
            end
          end
          line_len_nxt = '0;
          live_nxt     = LIVE_ALL;
        end else if ((item.rx_byte != CHAR_CR) && (line_len_r < LEN_W'(LINE_MAX))) begin
          // Append and drop every pattern that this byte breaks
          for (int k = 0; k < PAT_COUNT; k++) begin
            if (!((line_len_r < LEN_W'(PAT_LEN[k])) &&
                  (pat_byte(k, line_len_r[4:0]) == item.rx_byte))) begin
              live_nxt[k] = 1'b0;
            end
          end
          if ((line_len_r < LEN_W'(3)) && (IP_TEXT[line_len_r[1:0]] != item.rx_byte)) begin
            live_nxt[IP_BIT] = 1'b0;
          end
          wr_en        = 1'b1;
          line_len_nxt = line_len_r + LEN_W'(1);
        end
      end
      MODE_RELEASE: begin
        full_nxt = 1'b0;
      end
      MODE_READ: begin
        rd_en = (idx_ext < CMP_W'(pkt_len_r));
      end
      default: begin
      end
    endcase
  end

  assign step.connected    = conn_nxt;
  assign step.packet_ready = full_nxt;
  assign step.line_event   = ev;
  assign step.rd_hit       = rd_en;

  // Advance state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r  <= '0;
      live_r      <= LIVE_ALL;
      pkt_len_r   <= '0;
      conn_r      <= 1'b0;
      full_r      <= 1'b0;
      line_bank_r <= 1'b0;
    end else if (accept) begin
      line_len_r  <= line_len_nxt;
      live_r      <= live_nxt;
      pkt_len_r   <= pkt_len_nxt;
      conn_r      <= conn_nxt;
      full_r      <= full_nxt;
      line_bank_r <= line_bank_nxt;
    end
  end

  // Write the line buffer, read the packet buffer
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      buf_mem[line_bank_r][wr_addr] <= item.rx_byte;
    end
    if (accept && rd_en) begin
      rd_data_r <= buf_mem[~line_bank_r][rd_addr];
    end
  end

  assign rd_data = rd_data_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_len_r <= LEN_W'(LINE_MAX))
    else $error("line length past limit");

  a_lf_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (item.mode == MODE_RX) && (item.rx_byte == CHAR_LF)
    |=> (line_len_r == '0) && (live_r == LIVE_ALL))
    else $error("line state not cleared after line feed");

  a_store_swaps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (step.line_event == EV_STORED)
    |=> full_r && (line_bank_r != $past(line_bank_r)) && (pkt_len_r != '0))
    else $error("stored packet did not swap buffers");

endmodule
